### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers included by the RTL unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk, held off while i_rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked on every rising edge of i_clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### sv/cse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_pkg
// Types and codes of the CoAP server exchange state machine.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int TIMER_WIDTH_DEF = 40;
    localparam int CFG_TIMEOUT_W   = 32;
    localparam int CFG_MAXRT_W     = 4;

    localparam logic [CFG_TIMEOUT_W-1:0] CFG_TIMEOUT_RST = 32'd2;
    localparam logic [CFG_MAXRT_W-1:0]   CFG_MAXRT_RST   = 4'd4;

    // configuration register indexes
    typedef enum logic {
        REG_RESP_TIMEOUT = 1'b0,
        REG_MAX_RETRANS  = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        EV_REQUEST   = 3'd0,
        EV_READY     = 3'd1,
        EV_WAIT      = 3'd2,
        EV_HDL_ERROR = 3'd3,
        EV_ACK       = 3'd4,
        EV_RST       = 3'd5,
        EV_TICK      = 3'd6,
        EV_BAD_CODE  = 3'd7
    } t_mode;

    typedef enum logic [3:0] {
        XS_NONE        = 4'd0,
        XS_REQ_OK      = 4'd1,
        XS_ACK_SENT    = 4'd2,
        XS_WAIT_ACK    = 4'd3,
        XS_RETRY       = 4'd4,
        XS_DONE        = 4'd5,
        XS_ACK_TIMEOUT = 4'd6,
        XS_CLIENT_RST  = 4'd7,
        XS_INT_ERROR   = 4'd8,
        XS_BAD_REQUEST = 4'd9
    } t_xstate;

    typedef enum logic [2:0] {
        SK_NONE      = 3'd0,
        SK_PIGGYBACK = 3'd1,
        SK_SEPARATE  = 3'd2,
        SK_EMPTY_ACK = 3'd3,
        SK_BAD_REQ   = 3'd4,
        SK_SRV_ERROR = 3'd5
    } t_send;

    typedef struct packed {
        logic [2:0] mode;
        logic       is_con;
    } t_in;

    typedef struct packed {
        logic [3:0] exchange_state;
        logic [2:0] send_kind;
        logic       error;
        logic       finished;
    } t_out;

    // exchange control state, timers travel separately
    typedef struct packed {
        t_xstate                phase;
        logic                   confirmable;
        logic [CFG_MAXRT_W-1:0] retx_left;
    } t_ctl;

    function automatic t_out mk_out(t_xstate st, t_send sk, logic err, logic fin);
        t_out r;
        r.exchange_state = st;
        r.send_kind      = sk;
        r.error          = err;
        r.finished       = fin;
        return r;
    endfunction

endpackage

### sv/coap_server_exchange_fsm_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coap_server_exchange_fsm_unit
// Message-layer state machine of one CoAP server exchange.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------
//  event   | i_in_valid / o_in_ready    | i_in  (t_in: mode, is_con)
//  result  | o_out_valid / i_out_ready  | o_out (t_out)
//  config  | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
//  One event per cycle while results are taken; an event moves from the
//  input register through step logic into the state and result registers.
//  Synchronous active-low reset clears state and pipeline valids, resets config.
//  A stalled result holds the result register; the input register still
//  takes one more event, then o_in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module coap_server_exchange_fsm_unit
    import cse_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in                      i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out                     o_out,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [CFG_TIMEOUT_W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    logic                     r_s1_valid;
    t_in                      r_s1;
    logic                     r_out_valid;
    t_out                     r_out;
    t_ctl                     r_ctl;
    logic [TIMER_WIDTH-1:0]   r_timeout;
    logic [TIMER_WIDTH-1:0]   r_countdown;
    logic [CFG_TIMEOUT_W-1:0] r_cfg_timeout;
    logic [CFG_MAXRT_W-1:0]   r_cfg_maxrt;

    t_ctl                     n_ctl;
    logic [TIMER_WIDTH-1:0]   n_timeout;
    logic [TIMER_WIDTH-1:0]   n_countdown;
    t_out                     n_out;
    logic                     w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_s1_valid || w_out_free;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    cse_step #(
        .TimerWidth (TIMER_WIDTH)
    ) u_step (
        .i_ev          (r_s1),
        .i_ctl         (r_ctl),
        .i_timeout     (r_timeout),
        .i_countdown   (r_countdown),
        .i_cfg_timeout (r_cfg_timeout),
        .i_cfg_maxrt   (r_cfg_maxrt),
        .o_ctl         (n_ctl),
        .o_timeout     (n_timeout),
        .o_countdown   (n_countdown),
        .o_res         (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_ctl.phase       <= XS_NONE;
            r_ctl.confirmable <= 1'b0;
            r_ctl.retx_left   <= '0;
            r_timeout         <= '0;
            r_countdown       <= '0;
            r_cfg_timeout     <= CFG_TIMEOUT_RST;
            r_cfg_maxrt       <= CFG_MAXRT_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_RESP_TIMEOUT: r_cfg_timeout <= i_cfg_data;
                    REG_MAX_RETRANS:  r_cfg_maxrt   <= i_cfg_data[CFG_MAXRT_W-1:0];
                    default:          r_cfg_maxrt   <= r_cfg_maxrt;
                endcase
            end
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
                if (i_in_valid) begin
                    r_s1 <= i_in;
                end
            end
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_out       <= n_out;
                    r_ctl       <= n_ctl;
                    r_timeout   <= n_timeout;
                    r_countdown <= n_countdown;
                end
            end
        end
    end

    // timers only run while waiting for the client's ACK
    `ASSERT_CLK(a_timer_idle,
        (r_ctl.phase != XS_WAIT_ACK) |-> (r_timeout == '0 && r_countdown == '0),
        "timer live outside wait ack")
    // an illegal event always ends the exchange
    `ASSERT_CLK(a_err_fin, (r_out_valid && r_out.error) |-> r_out.finished,
        "error without finish")
    // piggybacked response only as a completed exchange
    `ASSERT_CLK(a_piggy_done,
        (r_out_valid && r_out.send_kind == SK_PIGGYBACK) |->
            (r_out.exchange_state == XS_DONE && r_out.finished),
        "piggyback outside done")
    // a held event in the input register is not dropped while the result stalls
    `ASSERT_CLK(a_s1_hold, (r_s1_valid && !w_out_free) |=> r_s1_valid,
        "input stage lost")

endmodule

### sv/cse_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_step
// Next-state and result logic for one event of the exchange.
// ----------------------------------------------------------------------------
module cse_step
    import cse_pkg::*;
#(
    parameter int TimerWidth = TIMER_WIDTH_DEF
) (
    input  t_in                      i_ev,
    input  t_ctl                     i_ctl,
    input  logic [TimerWidth-1:0]    i_timeout,
    input  logic [TimerWidth-1:0]    i_countdown,
    input  logic [CFG_TIMEOUT_W-1:0] i_cfg_timeout,
    input  logic [CFG_MAXRT_W-1:0]   i_cfg_maxrt,
    output t_ctl                     o_ctl,
    output logic [TimerWidth-1:0]    o_timeout,
    output logic [TimerWidth-1:0]    o_countdown,
    output t_out                     o_res
);

    logic [63:0]           w_cfg_ext;
    logic [TimerWidth-1:0] w_cfg_to;
    logic [TimerWidth-1:0] w_dbl;
    logic                  w_clr;

    assign w_cfg_ext = {{(64-CFG_TIMEOUT_W){1'b0}}, i_cfg_timeout};
    assign w_cfg_to  = w_cfg_ext[TimerWidth-1:0];
    // doubled timeout, saturating at all ones
    assign w_dbl     = i_timeout[TimerWidth-1] ? '1 : {i_timeout[TimerWidth-2:0], 1'b0};

    always_comb begin
        o_ctl       = i_ctl;
        o_timeout   = i_timeout;
        o_countdown = i_countdown;
        w_clr       = 1'b0;
        o_res       = mk_out(i_ctl.phase, SK_NONE, 1'b0, 1'b0);
        unique case (i_ev.mode)
            EV_REQUEST: begin
                if (i_ctl.phase != XS_NONE) begin
                    w_clr = 1'b1;
                    o_res = mk_out(XS_INT_ERROR, SK_SRV_ERROR, 1'b1, 1'b1);
                end else begin
                    o_ctl.phase       = XS_REQ_OK;
                    o_ctl.confirmable = i_ev.is_con;
                    o_res = mk_out(XS_REQ_OK, SK_NONE, 1'b0, 1'b0);
                end
            end
            EV_READY: begin
                if (i_ctl.phase == XS_REQ_OK) begin
                    w_clr = 1'b1;
                    o_res = mk_out(XS_DONE, i_ctl.confirmable ? SK_PIGGYBACK : SK_SEPARATE,
                                   1'b0, 1'b1);
                end else if (i_ctl.phase == XS_ACK_SENT && !i_ctl.confirmable) begin
                    w_clr = 1'b1;
                    o_res = mk_out(XS_DONE, SK_SEPARATE, 1'b0, 1'b1);
                end else if (i_ctl.phase == XS_ACK_SENT) begin
                    // separate confirmable response: arm retransmit timer
                    o_timeout       = w_cfg_to;
                    o_countdown     = w_cfg_to;
                    o_ctl.retx_left = i_cfg_maxrt;
                    o_ctl.phase     = XS_WAIT_ACK;
                    o_res = mk_out(XS_WAIT_ACK, SK_SEPARATE, 1'b0, 1'b0);
                end else begin
                    w_clr = 1'b1;
                    o_res = mk_out(XS_INT_ERROR, SK_SRV_ERROR, 1'b1, 1'b1);
                end
            end
            EV_WAIT: begin
                if (i_ctl.phase == XS_REQ_OK) begin
                    o_ctl.phase = XS_ACK_SENT;
                    o_res = mk_out(XS_ACK_SENT, i_ctl.confirmable ? SK_EMPTY_ACK : SK_NONE,
                                   1'b0, 1'b0);
                end else begin
                    w_clr = 1'b1;
                    o_res = mk_out(XS_INT_ERROR, SK_SRV_ERROR, 1'b1, 1'b1);
                end
            end
            EV_HDL_ERROR: begin
                w_clr = 1'b1;
                o_res = mk_out(XS_INT_ERROR, SK_SRV_ERROR,
                               !(i_ctl.phase == XS_REQ_OK || i_ctl.phase == XS_ACK_SENT),
                               1'b1);
            end
            EV_ACK: begin
                w_clr = 1'b1;
                if (i_ctl.phase == XS_WAIT_ACK) begin
                    o_res = mk_out(XS_DONE, SK_NONE, 1'b0, 1'b1);
                end else if (i_ctl.phase == XS_NONE) begin
                    o_res = mk_out(XS_BAD_REQUEST, SK_NONE, 1'b1, 1'b1);
                end else begin
                    o_res = mk_out(XS_INT_ERROR, SK_BAD_REQ, 1'b1, 1'b1);
                end
            end
            EV_RST: begin
                w_clr = 1'b1;
                if (i_ctl.phase == XS_NONE) begin
                    o_res = mk_out(XS_BAD_REQUEST, SK_NONE, 1'b1, 1'b1);
                end else begin
                    o_res = mk_out(XS_CLIENT_RST, SK_NONE, 1'b0, 1'b1);
                end
            end
            EV_TICK: begin
                if (i_ctl.phase != XS_WAIT_ACK) begin
                    o_res = mk_out(i_ctl.phase, SK_NONE, 1'b0, 1'b0);
                end else if (i_countdown[TimerWidth-1:1] != '0) begin
                    o_countdown = i_countdown - 1'b1;
                    o_res = mk_out(XS_WAIT_ACK, SK_NONE, 1'b0, 1'b0);
                end else if (i_ctl.retx_left == '0) begin
                    w_clr = 1'b1;
                    o_res = mk_out(XS_ACK_TIMEOUT, SK_NONE, 1'b0, 1'b1);
                end else begin
                    // expiry with retries left: retransmit, back off
                    o_timeout       = w_dbl;
                    o_countdown     = w_dbl;
                    o_ctl.retx_left = i_ctl.retx_left - 1'b1;
                    o_res = mk_out(XS_RETRY, SK_SEPARATE, 1'b0, 1'b0);
                end
            end
            EV_BAD_CODE: begin
                w_clr = 1'b1;
                o_res = mk_out(XS_BAD_REQUEST, SK_BAD_REQ, 1'b1, 1'b1);
            end
            default: begin
                w_clr = 1'b1;
                o_res = mk_out(XS_BAD_REQUEST, SK_BAD_REQ, 1'b1, 1'b1);
            end
        endcase
        if (w_clr) begin
            o_ctl.phase       = XS_NONE;
            o_ctl.confirmable = 1'b0;
            o_ctl.retx_left   = '0;
            o_timeout         = '0;
            o_countdown       = '0;
        end
    end

endmodule

### tb/cse_exchange_sb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_exchange_sb
// Exchange predictor and result checker for the CoAP server exchange FSM.
// Tracks phase, retransmit timer and retries per accepted event and keeps
// the expected results in acceptance order.
// ----------------------------------------------------------------------------
package cse_exchange_sb_pkg;

    import cse_pkg::*;

    class cse_exchange_sb;

        t_out                     expected_q[$];
        int unsigned              failures;

        logic [CFG_TIMEOUT_W-1:0] timeout_cfg;
        logic [CFG_MAXRT_W-1:0]   retrans_cfg;

        t_xstate                  phase;
        logic                     confirmable;
        logic [TIMER_WIDTH_DEF-1:0] timeout_len;
        logic [TIMER_WIDTH_DEF-1:0] countdown;
        logic [CFG_MAXRT_W-1:0]   retx_left;

        function new();
            timeout_cfg = CFG_TIMEOUT_RST;
            retrans_cfg = CFG_MAXRT_RST;
            failures    = 0;
            drop_exchange();
        endfunction

        function void set_reg(t_reg_idx idx, logic [CFG_TIMEOUT_W-1:0] value);
            if (idx == REG_RESP_TIMEOUT)
                timeout_cfg = value;
            else
                retrans_cfg = value[CFG_MAXRT_W-1:0];
        endfunction

        function void drop_exchange();
            phase       = XS_NONE;
            confirmable = 1'b0;
            timeout_len = '0;
            countdown   = '0;
            retx_left   = '0;
        endfunction

        function t_out outcome(t_xstate st, t_send sk, logic err, logic fin);
            t_out r;
            r.exchange_state = st;
            r.send_kind      = sk;
            r.error          = err;
            r.finished       = fin;
            return r;
        endfunction

        // final outcome: exchange is torn down and the block goes idle
        function t_out close_out(t_xstate st, t_send sk, logic err);
            drop_exchange();
            return outcome(st, sk, err, 1'b1);
        endfunction

        function t_out predict(t_in ev);
            logic [TIMER_WIDTH_DEF-1:0] full;
            full = '1;
            case (t_mode'(ev.mode))
                EV_REQUEST: begin
                    if (phase != XS_NONE)
                        return close_out(XS_INT_ERROR, SK_SRV_ERROR, 1'b1);
                    phase       = XS_REQ_OK;
                    confirmable = ev.is_con;
                    return outcome(XS_REQ_OK, SK_NONE, 1'b0, 1'b0);
                end
                EV_READY: begin
                    if (phase == XS_REQ_OK)
                        return close_out(XS_DONE, confirmable ? SK_PIGGYBACK : SK_SEPARATE,
                                         1'b0);
                    if (phase == XS_ACK_SENT) begin
                        if (!confirmable)
                            return close_out(XS_DONE, SK_SEPARATE, 1'b0);
                        timeout_len = TIMER_WIDTH_DEF'(timeout_cfg);
                        countdown   = timeout_len;
                        retx_left   = retrans_cfg;
                        phase       = XS_WAIT_ACK;
                        return outcome(XS_WAIT_ACK, SK_SEPARATE, 1'b0, 1'b0);
                    end
                    return close_out(XS_INT_ERROR, SK_SRV_ERROR, 1'b1);
                end
                EV_WAIT: begin
                    if (phase == XS_REQ_OK) begin
                        phase = XS_ACK_SENT;
                        return outcome(XS_ACK_SENT, confirmable ? SK_EMPTY_ACK : SK_NONE,
                                       1'b0, 1'b0);
                    end
                    return close_out(XS_INT_ERROR, SK_SRV_ERROR, 1'b1);
                end
                EV_HDL_ERROR: begin
                    if (phase == XS_REQ_OK || phase == XS_ACK_SENT)
                        return close_out(XS_INT_ERROR, SK_SRV_ERROR, 1'b0);
                    return close_out(XS_INT_ERROR, SK_SRV_ERROR, 1'b1);
                end
                EV_ACK: begin
                    if (phase == XS_WAIT_ACK)
                        return close_out(XS_DONE, SK_NONE, 1'b0);
                    if (phase == XS_NONE)
                        return close_out(XS_BAD_REQUEST, SK_NONE, 1'b1);
                    return close_out(XS_INT_ERROR, SK_BAD_REQ, 1'b1);
                end
                EV_RST: begin
                    if (phase == XS_NONE)
                        return close_out(XS_BAD_REQUEST, SK_NONE, 1'b1);
                    return close_out(XS_CLIENT_RST, SK_NONE, 1'b0);
                end
                EV_TICK: begin
                    if (phase != XS_WAIT_ACK)
                        return outcome(phase, SK_NONE, 1'b0, 1'b0);
                    if (countdown > 1) begin
                        countdown = countdown - 1'b1;
                        return outcome(XS_WAIT_ACK, SK_NONE, 1'b0, 1'b0);
                    end
                    if (retx_left == 0)
                        return close_out(XS_ACK_TIMEOUT, SK_NONE, 1'b0);
                    // backoff doubles, held at the top of the timer range
                    if (timeout_len > (full >> 1))
                        timeout_len = full;
                    else
                        timeout_len = timeout_len << 1;
                    countdown = timeout_len;
                    retx_left = retx_left - 1'b1;
                    return outcome(XS_RETRY, SK_SEPARATE, 1'b0, 1'b0);
                end
                default: return close_out(XS_BAD_REQUEST, SK_BAD_REQ, 1'b1);
            endcase
        endfunction

        function void note_event(t_in ev);
            expected_q.push_back(predict(ev));
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                $error("result with no transaction pending: %h", got);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            if (got.exchange_state !== want.exchange_state) begin
                $error("exchange_state expected %0d got %0d",
                       want.exchange_state, got.exchange_state);
                failures++;
            end
            if (got.send_kind !== want.send_kind) begin
                $error("send_kind expected %0d got %0d", want.send_kind, got.send_kind);
                failures++;
            end
            if (got.error !== want.error) begin
                $error("error expected %0d got %0d", want.error, got.error);
                failures++;
            end
            if (got.finished !== want.finished) begin
                $error("finished expected %0d got %0d", want.finished, got.finished);
                failures++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of coap_server_exchange_fsm_unit. A directed run walks the
// exchange phases with legal and illegal events, then random exchanges (mostly well formed, some
// noise) run under several timeout and retransmit settings with random
// idle cycles on both handshakes. Every result is checked in order.
// ----------------------------------------------------------------------------
module tb_top;

    import cse_pkg::*;
    import cse_exchange_sb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_SETTINGS  = 7;
    localparam int PER_SETTING = 140;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    t_in                      in_data;
    logic                     out_valid;
    logic                     out_ready;
    t_out                     out_data;
    logic                     cfg_we;
    logic                     cfg_idx;
    logic [CFG_TIMEOUT_W-1:0] cfg_data;

    cse_exchange_sb           sb;
    bit                       no_gaps;
    int unsigned              events_sent;
    int unsigned              cycles;

    logic [CFG_TIMEOUT_W-1:0] timeout_set [N_SETTINGS] =
        '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd3, 32'd1, 32'd2, 32'd2};
    logic [CFG_MAXRT_W-1:0]   retrans_set [N_SETTINGS] =
        '{4'd0, 4'd2, 4'd15, 4'd1, 4'd15, 4'd3, 4'd4};

    coap_server_exchange_fsm_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("coap_server_exchange_fsm_unit verification failed");
            $finish;
        end
    end

    function automatic t_in mk_ev(t_mode m, logic con);
        t_in ev;
        ev.mode   = m;
        ev.is_con = con;
        return ev;
    endfunction

    // one event transaction; called right after a rising edge
    task automatic send_event(t_in ev);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do @(posedge clk); while (!in_ready);
        sb.note_event(ev);
        events_sent++;
        if ($urandom_range(0, 59) == 0)
            no_gaps = !no_gaps;
    endtask

    task automatic send_mode(t_mode m);
        send_event(mk_ev(m, 1'($urandom_range(0, 1))));
    endtask

    task automatic cfg_write(t_reg_idx idx, logic [CFG_TIMEOUT_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    // stop sending and let every pending result come back
    task automatic drain_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic run_directed();
        t_in seq[$];
        seq = '{mk_ev(EV_REQUEST, 1'b1), mk_ev(EV_WAIT, 1'b0), mk_ev(EV_READY, 1'b1),
                mk_ev(EV_TICK, 1'b0), mk_ev(EV_TICK, 1'b1), mk_ev(EV_ACK, 1'b0),
                mk_ev(EV_BAD_CODE, 1'b1), mk_ev(EV_ACK, 1'b1), mk_ev(EV_RST, 1'b0),
                mk_ev(EV_REQUEST, 1'b0), mk_ev(EV_WAIT, 1'b1), mk_ev(EV_READY, 1'b0),
                mk_ev(EV_REQUEST, 1'b1), mk_ev(EV_READY, 1'b0),
                mk_ev(EV_REQUEST, 1'b0), mk_ev(EV_REQUEST, 1'b1),
                mk_ev(EV_REQUEST, 1'b1), mk_ev(EV_TICK, 1'b1), mk_ev(EV_WAIT, 1'b0),
                mk_ev(EV_WAIT, 1'b1),
                mk_ev(EV_REQUEST, 1'b1), mk_ev(EV_HDL_ERROR, 1'b1),
                mk_ev(EV_REQUEST, 1'b0), mk_ev(EV_ACK, 1'b0),
                mk_ev(EV_HDL_ERROR, 1'b0), mk_ev(EV_READY, 1'b1)};
        foreach (seq[i])
            send_event(seq[i]);
    endtask

    // mostly complete exchanges with random content, the rest plain noise
    task automatic run_exchanges(int unsigned target);
        int unsigned stop_at;
        int          n_ticks;
        int          pick;
        stop_at = events_sent + target;
        while (events_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                send_mode(EV_REQUEST);
                if ($urandom_range(0, 7) == 0)
                    send_mode(t_mode'($urandom_range(0, 7)));
                if (sb.phase == XS_REQ_OK && $urandom_range(0, 2) != 0)
                    send_mode(EV_WAIT);
                if (sb.phase != XS_NONE)
                    send_mode(($urandom_range(0, 9) == 0) ? EV_HDL_ERROR : EV_READY);
                n_ticks = $urandom_range(0, 64);
                while (sb.phase == XS_WAIT_ACK && n_ticks > 0) begin
                    send_mode(EV_TICK);
                    n_ticks--;
                end
                if (sb.phase != XS_NONE) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        send_mode(EV_ACK);
                    else if (pick < 8)
                        send_mode(EV_RST);
                    else if (pick == 8)
                        send_mode(EV_BAD_CODE);
                end
            end else begin
                send_mode(t_mode'($urandom_range(0, 7)));
            end
        end
    endtask

    // result side: random stall before each result transaction
    initial begin
        int stall;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(out_data);
        end
    end

    initial begin
        sb          = new();
        no_gaps     = 1'b0;
        events_sent = 0;
        cycles      = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_ready <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_idx   <= REG_RESP_TIMEOUT;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain_idle();

        for (int s = 0; s < N_SETTINGS; s++) begin
            cfg_write(REG_RESP_TIMEOUT, timeout_set[s]);
            cfg_write(REG_MAX_RETRANS, CFG_TIMEOUT_W'(retrans_set[s]));
            no_gaps = ($urandom_range(0, 3) == 0);
            run_exchanges(PER_SETTING);
            drain_idle();
        end

        if (sb.failures == 0)
            $display("coap_server_exchange_fsm_unit verification clean");
        else
            $display("coap_server_exchange_fsm_unit verification failed");
        $finish;
    end

endmodule

### coap_server_exchange_fsm_unit.f
+incdir+sv
sv/cse_pkg.sv
sv/cse_step.sv
sv/coap_server_exchange_fsm_unit.sv
tb/cse_exchange_sb.sv
tb/tb_top.sv
